FILE: design/lcsr_pkg.sv
package lcsr_pkg;

    // sample length of the converter frame
    localparam int LCSR_SAMPLE_BITS = 24;

    // field widths
    localparam int LCSR_RAW_W  = 24;
    localparam int LCSR_TARE_W = 24;
    localparam int LCSR_CPT_W  = 16;
    localparam int LCSR_LB_W   = 18;
    localparam int LCSR_OZ_W   = 5;
    localparam int LCSR_TZ_W   = 4;

    // unit conversion
    localparam int LCSR_TENTHS_PER_OZ = 10;
    localparam int LCSR_OZ_LOG2       = 4;

    // register reset values
    localparam logic [LCSR_TARE_W-1:0] LCSR_TARE_RESET = 24'd8335700;
    localparam logic [LCSR_CPT_W-1:0]  LCSR_CPT_RESET  = 16'd570;

    // register map
    localparam int LCSR_CFG_IDX_W = 1;
    localparam logic [LCSR_CFG_IDX_W-1:0] LCSR_REG_TARE = 1'b0;
    localparam logic [LCSR_CFG_IDX_W-1:0] LCSR_REG_CPT  = 1'b1;

endpackage

FILE: design/lcsr_ifs.sv
interface lcsr_tick_if;
    logic valid;
    logic ready;
    logic data_level;

    modport source (output valid, output data_level, input ready);
    modport sink (input valid, input data_level, output ready);
endinterface

interface lcsr_result_if;
    import lcsr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         clock_out;
    logic                         sample_done;
    logic [LCSR_RAW_W-1:0]        raw_count;
    logic signed [LCSR_LB_W-1:0]  pounds;
    logic signed [LCSR_OZ_W-1:0]  ounces;
    logic [LCSR_TZ_W-1:0]         tenth_ounces;

    modport source (
        output valid, output clock_out, output sample_done, output raw_count,
        output pounds, output ounces, output tenth_ounces, input ready
    );
    modport sink (
        input valid, input clock_out, input sample_done, input raw_count,
        input pounds, input ounces, input tenth_ounces, output ready
    );
endinterface

FILE: design/lcsr_div.sv
module lcsr_div #(
    parameter int WIDTH = lcsr_pkg::LCSR_RAW_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [WIDTH-1:0]                dividend,
    input  logic [lcsr_pkg::LCSR_CPT_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [WIDTH-1:0]                quotient,
    output logic [lcsr_pkg::LCSR_CPT_W-1:0] remainder
);
    import lcsr_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0]      quo_reg, quo_next;
    logic [LCSR_CPT_W-1:0] rem_reg, rem_next;
    logic [LCSR_CPT_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [LCSR_CPT_W:0]   partial;
    logic [LCSR_CPT_W:0]   trial;
    logic                  fits;

    // one restoring step: bring down the next dividend bit
    assign partial = {rem_reg, quo_reg[WIDTH-1]};
    assign fits    = partial >= {1'b0, dvs_reg};
    assign trial   = partial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? trial[LCSR_CPT_W-1:0] : partial[LCSR_CPT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/load_cell_serial_read_and_scale.sv
// Serial reader for a 24-bit bridge converter with weight scaling. Each transfer on
// the tick channel is one tick of the slow serial clock and carries the sampled data
// line level; each tick yields exactly one transfer on the result channel. While the
// data line is high the serial clock stays low; once it falls, SAMPLE_BITS clock
// pulses follow (one tick high, one tick low, data shifted in MSB first on the low
// tick), then one extra pulse whose low tick presents the reading with its top bit
// inverted, converted to pounds, ounces and tenths using tare_offset and
// counts_per_tenth_ounce (truncating signed division, zero divisor taken as 1).
// Timing: an ordinary tick's result sits in the output register the next cycle. The
// conversion tick steps through scale start, scale wait and tenth wait on the shared
// restoring divider (MW = max(SAMPLE_BITS, 24) bits wide), which yields one quotient
// bit per cycle and runs twice: the scale divide and the divide by ten. The tick
// channel is not ready while a conversion runs.
// Configuration writes take effect at once and are meant for idle periods.
module load_cell_serial_read_and_scale #(
    parameter int SAMPLE_BITS = lcsr_pkg::LCSR_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lcsr_pkg::LCSR_CFG_IDX_W-1:0] cfg_index,
    input  logic [lcsr_pkg::LCSR_TARE_W-1:0]    cfg_data,
    lcsr_tick_if.sink                           tick,
    lcsr_result_if.source                       result
);
    import lcsr_pkg::*;

    // magnitude width of the conversion and pulse counter width
    localparam int MW = (SAMPLE_BITS > LCSR_RAW_W) ? SAMPLE_BITS : LCSR_RAW_W;
    localparam int DW = MW + 1;
    localparam int CW = $clog2(SAMPLE_BITS + 1);

    // serial frame phase; the unused code behaves as waiting
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // conversion sequencer
    typedef enum logic [1:0] {
        S_IDLE        = 2'd0,
        S_SCALE_START = 2'd1,
        S_SCALE_WAIT  = 2'd2,
        S_TENTH_WAIT  = 2'd3
    } state_t;

    // configuration
    logic [LCSR_TARE_W-1:0]      tare_reg, tare_next;
    logic [LCSR_CPT_W-1:0]       cpt_reg, cpt_next;

    // serial frame
    phase_t                      phase_reg, phase_next;
    logic [CW-1:0]               pulse_cnt_reg, pulse_cnt_next;
    logic [SAMPLE_BITS-1:0]      shift_reg, shift_next;

    // conversion
    state_t                      state_reg, state_next;
    logic [MW-1:0]               mag_reg, mag_next;
    logic                        neg_reg, neg_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic                        clock_out_reg, clock_out_next;
    logic                        done_reg, done_next;
    logic [LCSR_RAW_W-1:0]       raw_reg, raw_next;
    logic signed [LCSR_LB_W-1:0] lb_reg, lb_next;
    logic signed [LCSR_OZ_W-1:0] oz_reg, oz_next;
    logic [LCSR_TZ_W-1:0]        tz_reg, tz_next;

    // shared divider
    logic                        div_start;
    logic [MW-1:0]               div_dividend;
    logic [LCSR_CPT_W-1:0]       div_divisor;
    logic                        div_busy;
    logic                        div_done;
    logic [MW-1:0]               div_quotient;
    logic [LCSR_CPT_W-1:0]       div_remainder;

    // reading and difference to tare
    logic                        tick_xfer;
    logic                        out_free;
    logic [SAMPLE_BITS-1:0]      reading;
    logic [MW-1:0]               reading_ext;
    logic [DW-1:0]               diff;
    logic [DW-1:0]               diff_abs;
    logic [LCSR_CPT_W-1:0]       cpt_eff;
    logic [LCSR_LB_W-1:0]        lb_mag;
    logic [LCSR_OZ_W-1:0]        oz_mag;

    // output slot frees when empty or being taken this cycle
    assign out_free   = !out_valid_reg || result.ready;
    assign tick.ready = (state_reg == S_IDLE) && out_free;
    assign tick_xfer  = tick.valid && tick.ready;

    // top bit inverted gives offset binary
    assign reading     = shift_reg ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign reading_ext = MW'(reading);
    assign diff        = DW'(reading_ext) - DW'(tare_reg);
    assign diff_abs    = diff[DW-1] ? (~diff + 1'b1) : diff;

    assign cpt_eff = (cpt_reg == '0) ? LCSR_CPT_W'(1) : cpt_reg;

    // ounces total split: low bits are ounces, the rest whole pounds
    assign lb_mag = div_quotient[LCSR_OZ_LOG2 +: LCSR_LB_W];
    assign oz_mag = LCSR_OZ_W'(div_quotient[LCSR_OZ_LOG2-1:0]);

    // first run: magnitude / counts, second run: tenths / 10
    assign div_start    = (state_reg == S_SCALE_START)
                       || ((state_reg == S_SCALE_WAIT) && div_done);
    assign div_dividend = (state_reg == S_SCALE_START) ? mag_reg : div_quotient;
    assign div_divisor  = (state_reg == S_SCALE_START) ? cpt_eff
                                                       : LCSR_CPT_W'(LCSR_TENTHS_PER_OZ);

    lcsr_div #(
        .WIDTH (MW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        tare_next      = tare_reg;
        cpt_next       = cpt_reg;
        phase_next     = phase_reg;
        pulse_cnt_next = pulse_cnt_reg;
        shift_next     = shift_reg;
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !result.ready;
        clock_out_next = clock_out_reg;
        done_next      = done_reg;
        raw_next       = raw_reg;
        lb_next        = lb_reg;
        oz_next        = oz_reg;
        tz_next        = tz_reg;

        // register writes
        if (cfg_write)
        begin
            case (cfg_index)
                LCSR_REG_TARE: tare_next = cfg_data;
                LCSR_REG_CPT:  cpt_next  = cfg_data[LCSR_CPT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (tick_xfer)
                begin
                    // ordinary tick result unless the conversion starts below
                    out_valid_next = 1'b1;
                    clock_out_next = 1'b0;
                    done_next      = 1'b0;
                    raw_next       = '0;
                    lb_next        = '0;
                    oz_next        = '0;
                    tz_next        = '0;
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            clock_out_next = 1'b1;
                            phase_next     = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            if (pulse_cnt_reg < CW'(SAMPLE_BITS))
                            begin
                                shift_next     = {shift_reg[SAMPLE_BITS-2:0], tick.data_level};
                                pulse_cnt_next = pulse_cnt_reg + 1'b1;
                                phase_next     = PH_HIGH;
                            end
                            else
                            begin
                                // extra pulse low tick: run the conversion
                                out_valid_next = 1'b0;
                                raw_next       = reading_ext[LCSR_RAW_W-1:0];
                                mag_next       = diff_abs[MW-1:0];
                                neg_next       = diff[DW-1];
                                state_next     = S_SCALE_START;
                                phase_next     = PH_WAIT;
                                pulse_cnt_next = '0;
                                shift_next     = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                            if (!tick.data_level)
                            begin
                                phase_next     = PH_HIGH;
                                pulse_cnt_next = '0;
                                shift_next     = '0;
                            end
                        end
                    endcase
                end
            end
            S_SCALE_START:
            begin
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_TENTH_WAIT;
                end
            end
            S_TENTH_WAIT:
            begin
                if (div_done)
                begin
                    // pounds and ounces carry the sign of the difference; tenths stay a magnitude
                    out_valid_next = 1'b1;
                    clock_out_next = 1'b0;
                    done_next      = 1'b1;
                    lb_next        = neg_reg ? -$signed(lb_mag) : $signed(lb_mag);
                    oz_next        = neg_reg ? -$signed(oz_mag) : $signed(oz_mag);
                    tz_next        = div_remainder[LCSR_TZ_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg      <= LCSR_TARE_RESET;
            cpt_reg       <= LCSR_CPT_RESET;
            phase_reg     <= PH_WAIT;
            pulse_cnt_reg <= '0;
            shift_reg     <= '0;
            state_reg     <= S_IDLE;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            clock_out_reg <= 1'b0;
            done_reg      <= 1'b0;
            raw_reg       <= '0;
            lb_reg        <= '0;
            oz_reg        <= '0;
            tz_reg        <= '0;
        end
        else
        begin
            tare_reg      <= tare_next;
            cpt_reg       <= cpt_next;
            phase_reg     <= phase_next;
            pulse_cnt_reg <= pulse_cnt_next;
            shift_reg     <= shift_next;
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            clock_out_reg <= clock_out_next;
            done_reg      <= done_next;
            raw_reg       <= raw_next;
            lb_reg        <= lb_next;
            oz_reg        <= oz_next;
            tz_reg        <= tz_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.clock_out    = clock_out_reg;
    assign result.sample_done  = done_reg;
    assign result.raw_count    = raw_reg;
    assign result.pounds       = lb_reg;
    assign result.ounces       = oz_reg;
    assign result.tenth_ounces = tz_reg;

    // no tick is taken while a conversion is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !tick.ready)
    else $error("tick ready during conversion");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_SCALE_WAIT) || (state_reg == S_TENTH_WAIT)))
    else $error("divider done outside a wait state");

    // divider never gets a start while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
    else $error("divider started while busy");

    // a finished reading is presented on a low clock with tenths below ten
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.sample_done) |->
            (!result.clock_out && (result.tenth_ounces < LCSR_TZ_W'(LCSR_TENTHS_PER_OZ))))
    else $error("bad finished reading");

    // ounces and pounds never disagree in sign
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.sample_done && (result.ounces != '0) && (result.pounds != '0))
            |-> (result.ounces[LCSR_OZ_W-1] == result.pounds[LCSR_LB_W-1]))
    else $error("sign mismatch in result");

endmodule
